FILE: hdl/hpwl_pkg.sv
`default_nettype none
package hpwl_pkg;

   localparam int TablePagesDefault = 32;
   localparam int MaxActions        = 32;
   localparam int PageW             = 52;
   localparam int ProtW             = 3;
   localparam int CountW            = 32;
   localparam int KeepW             = 6;

   localparam logic [ProtW-1:0]  NO_ACCESS   = 3'd0;
   localparam logic [ProtW-1:0]  WRITE_BIT   = 3'd2;
   localparam logic              SHARED_FLAG = 1'b1;
   localparam logic [CountW-1:0] COUNT_MAX   = '1;

   typedef enum logic [1:0] {
      MODE_TRACK     = 2'd0,
      MODE_UNTRACK   = 2'd1,
      MODE_REBALANCE = 2'd2,
      MODE_NOP       = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_PROTECT = 2'd1,
      KIND_DONE    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [PageW-1:0]  page;
      logic              shared;
      logic [ProtW-1:0]  orig_prot;
      logic [ProtW-1:0]  cur_prot;
      logic [CountW-1:0] count;
   } entry_type;

endpackage
`default_nettype wire

FILE: hdl/hpwl_if.sv
`default_nettype none
interface hpwl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [51:0] page_number;
   logic        shared_mapping;
   logic [2:0]  page_prot;
   logic [5:0]  keep_count;
   logic [2:0]  lock_mask;

   modport source (output valid, mode, page_number, shared_mapping, page_prot, keep_count,
                   lock_mask, input ready);
   modport sink (input valid, mode, page_number, shared_mapping, page_prot, keep_count,
                 lock_mask, output ready);
endinterface

interface hpwl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [51:0] out_page;
   logic [2:0]  new_prot;
   logic [1:0]  status;
   logic [5:0]  eligible_count;
   logic [31:0] page_count;
   logic        last;

   modport source (output valid, kind, out_page, new_prot, status, eligible_count,
                   page_count, last, input ready);
   modport sink (input valid, kind, out_page, new_prot, status, eligible_count,
                 page_count, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/hpwl_table.sv
`default_nettype none
module hpwl_table #(
   parameter int TABLE_PAGES = hpwl_pkg::TablePagesDefault,
   localparam int IW = $clog2(TABLE_PAGES)
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [IW-1:0]       wr_addr,
   input  wire hpwl_pkg::entry_type wr_data,
   input  wire logic                rd_en,
   input  wire logic [IW-1:0]       rd_addr,
   output      hpwl_pkg::entry_type rd_data
);
   import hpwl_pkg::*;

   entry_type mem [TABLE_PAGES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: hdl/hot_page_write_lock_policy_unit.sv
// page write-lock policy table
// req_bus takes one command beat: track, untrack or rebalance. rsp_bus returns
// result beats; the final beat of a command has last set.
// the entry data sits in a single-port-read, single-port-write memory; every
// command sweeps all TABLE_PAGES entries, one read per cycle, then takes a
// finish step.
// track and untrack: one sweep, one ack beat.
// rebalance: one sweep per ranked page plus a final sweep, so E+1 sweeps
// for E eligible pages; each sweep finds the next maximum (count, then page
// number) and may emit one protect beat.
// the single memory read port sets the one-entry-per-cycle sweep.
// one command is worked at a time; req_bus is ready whenever the sequencer
// is idle, even if the last result still waits in the output register.
// when rsp_bus stalls the sequencer holds before emitting its next beat.
// reset clears all valid bits and the sequencer; no clearing pass is needed.
`default_nettype none
module hot_page_write_lock_policy_unit #(
   parameter int TABLE_PAGES = hpwl_pkg::TablePagesDefault
) (
   input wire logic  clock,
   input wire logic  reset,
   hpwl_req_if.sink   req_bus,
   hpwl_rsp_if.source rsp_bus
);
   import hpwl_pkg::*;

   localparam int IW = $clog2(TABLE_PAGES);
   localparam int CW = $clog2(TABLE_PAGES + 1);

   state_type state_ff, state_in;
   logic [TABLE_PAGES-1:0] valid_ff, valid_in;
   logic [TABLE_PAGES-1:0] ranked_ff, ranked_in;

   logic [1:0]        op_mode_ff, op_mode_in;
   logic [PageW-1:0]  op_page_ff, op_page_in;
   logic              op_shared_ff, op_shared_in;
   logic [ProtW-1:0]  op_prot_ff, op_prot_in;
   logic [KeepW-1:0]  op_keep_ff, op_keep_in;
   logic [ProtW-1:0]  op_mask_ff, op_mask_in;

   logic [CW-1:0]     iss_ff, iss_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;

   logic              found_ff, found_in;
   logic [IW-1:0]     hit_idx_ff, hit_idx_in;
   logic              free_ff, free_in;
   logic [IW-1:0]     free_idx_ff, free_idx_in;
   logic              best_ok_ff, best_ok_in;
   logic [IW-1:0]     best_idx_ff, best_idx_in;
   entry_type         best_ff, best_in;

   logic [KeepW-1:0]  elig_ff, elig_in;
   logic [KeepW-1:0]  rank_ff, rank_in;
   logic [KeepW-1:0]  act_ff, act_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [PageW-1:0]  rsp_page_ff, rsp_page_in;
   logic [ProtW-1:0]  rsp_prot_ff, rsp_prot_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [KeepW-1:0]  rsp_elig_ff, rsp_elig_in;
   logic [CountW-1:0] rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   entry_type         wr_data;
   logic              rd_en;
   entry_type         rd_data;

   logic              accept;
   logic              slot_free;
   logic              ent_valid;
   logic              ent_elig;
   logic              better;
   entry_type         upd;

   hpwl_table #(.TABLE_PAGES(TABLE_PAGES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (iss_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && (state_ff == ST_IDLE);
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign rd_en         = (state_ff == ST_SCAN) && (iss_ff < CW'(TABLE_PAGES));

   assign ent_valid = valid_ff[rd_idx_ff];
   assign ent_elig  = ent_valid && (rd_data.shared != SHARED_FLAG) &&
                      ((rd_data.orig_prot & WRITE_BIT) != NO_ACCESS);
   assign better    = !best_ok_ff || (rd_data.count > best_ff.count) ||
                      ((rd_data.count == best_ff.count) && (rd_data.page > best_ff.page));

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      ranked_in     = ranked_ff;
      op_mode_in    = op_mode_ff;
      op_page_in    = op_page_ff;
      op_shared_in  = op_shared_ff;
      op_prot_in    = op_prot_ff;
      op_keep_in    = op_keep_ff;
      op_mask_in    = op_mask_ff;
      iss_in        = iss_ff;
      rd_vld_in     = rd_en;
      rd_idx_in     = iss_ff[IW-1:0];
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      best_ok_in    = best_ok_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      elig_in       = elig_ff;
      rank_in       = rank_ff;
      act_in        = act_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_prot_in   = rsp_prot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_elig_in   = rsp_elig_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = best_idx_ff;
      wr_data       = best_ff;
      upd           = best_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_mode_in   = req_bus.mode;
               op_page_in   = req_bus.page_number;
               op_shared_in = req_bus.shared_mapping;
               op_prot_in   = req_bus.page_prot;
               op_keep_in   = req_bus.keep_count;
               op_mask_in   = req_bus.lock_mask;
               ranked_in    = '0;
               elig_in      = '0;
               rank_in      = '0;
               act_in       = '0;
               iss_in       = '0;
               found_in     = 1'b0;
               free_in      = 1'b0;
               best_ok_in   = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               iss_in = iss_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (ent_valid && (rd_data.page == op_page_ff) && !found_ff) begin
                  found_in   = 1'b1;
                  hit_idx_in = rd_idx_ff;
               end
               if (!ent_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (ent_elig && (rank_ff == '0)) begin
                  elig_in = elig_ff + KeepW'(1);
               end
               if (ent_elig && !ranked_ff[rd_idx_ff] && better) begin
                  best_ok_in  = 1'b1;
                  best_idx_in = rd_idx_ff;
                  best_in     = rd_data;
               end
            end
            if (!rd_en && !rd_vld_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_kind_in   = KIND_ACK;
               rsp_page_in   = '0;
               rsp_prot_in   = NO_ACCESS;
               rsp_status_in = STATUS_OK;
               rsp_elig_in   = '0;
               rsp_count_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
               case (op_mode_ff)
                  MODE_TRACK: begin
                     rsp_valid_in = 1'b1;
                     if (found_ff || free_ff) begin
                        wr_en             = 1'b1;
                        wr_addr           = found_ff ? hit_idx_ff : free_idx_ff;
                        wr_data.page      = op_page_ff;
                        wr_data.shared    = op_shared_ff;
                        wr_data.orig_prot = op_prot_ff;
                        wr_data.cur_prot  = op_prot_ff;
                        wr_data.count     = '0;
                        valid_in[wr_addr] = 1'b1;
                     end else begin
                        rsp_status_in = STATUS_FULL;
                     end
                  end
                  MODE_UNTRACK: begin
                     rsp_valid_in = 1'b1;
                     if (found_ff) begin
                        valid_in[hit_idx_ff] = 1'b0;
                     end else begin
                        rsp_status_in = STATUS_NOT_FOUND;
                     end
                  end
                  MODE_REBALANCE: begin
                     if (!best_ok_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_DONE;
                        rsp_elig_in  = elig_ff;
                     end else begin
                        ranked_in[best_idx_ff] = 1'b1;
                        rank_in    = rank_ff + KeepW'(1);
                        iss_in     = '0;
                        best_ok_in = 1'b0;
                        state_in   = ST_SCAN;
                        if (act_ff < KeepW'(MaxActions)) begin
                           if (rank_ff < op_keep_ff) begin
                              if ((best_ff.cur_prot & WRITE_BIT) == NO_ACCESS) begin
                                 upd.cur_prot = best_ff.orig_prot;
                                 if (best_ff.count != COUNT_MAX) begin
                                    upd.count = best_ff.count + CountW'(1);
                                 end
                                 wr_en = 1'b1;
                              end
                           end else if ((best_ff.cur_prot & WRITE_BIT) != NO_ACCESS) begin
                              upd.cur_prot = best_ff.orig_prot & ~op_mask_ff;
                              wr_en        = 1'b1;
                           end
                        end
                        wr_data = upd;
                        if (wr_en) begin
                           act_in       = act_ff + KeepW'(1);
                           rsp_valid_in = 1'b1;
                           rsp_kind_in  = KIND_PROTECT;
                           rsp_page_in  = upd.page;
                           rsp_prot_in  = upd.cur_prot;
                           rsp_count_in = upd.count;
                           rsp_last_in  = 1'b0;
                        end
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ranked_ff     <= ranked_in;
      op_mode_ff    <= op_mode_in;
      op_page_ff    <= op_page_in;
      op_shared_ff  <= op_shared_in;
      op_prot_ff    <= op_prot_in;
      op_keep_ff    <= op_keep_in;
      op_mask_ff    <= op_mask_in;
      iss_ff        <= iss_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      best_ok_ff    <= best_ok_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      elig_ff       <= elig_in;
      rank_ff       <= rank_in;
      act_ff        <= act_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_prot_ff   <= rsp_prot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_elig_ff   <= rsp_elig_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.kind           = rsp_kind_ff;
   assign rsp_bus.out_page       = rsp_page_ff;
   assign rsp_bus.new_prot       = rsp_prot_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.eligible_count = rsp_elig_ff;
   assign rsp_bus.page_count     = rsp_count_ff;
   assign rsp_bus.last           = rsp_last_ff;

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == ST_SCAN))
      else $error("memory read data outside a sweep");

   a_write_in_fin: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_FIN) && slot_free)
      else $error("table write outside the finish step");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN))
      else $error("accepted command did not start a sweep");

   a_action_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (act_ff <= KeepW'(MaxActions)))
      else $error("protect action count over limit");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> $stable(rsp_page_ff) && $stable(rsp_kind_ff))
      else $error("stalled result overwritten");
endmodule
`default_nettype wire

FILE: sim/tb_hot_page_write_lock_policy_unit.sv
`default_nettype none
module tb_hot_page_write_lock_policy_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import hpwl_pkg::*;

   localparam int Pages = TablePagesDefault;

   typedef struct {
      mode_type         mode;
      logic [PageW-1:0] page;
      logic             shared;
      logic [ProtW-1:0] prot;
      logic [KeepW-1:0] keep;
      logic [ProtW-1:0] mask;
      bit               drain_first;
   } command_type;

   typedef struct {
      kind_type          kind;
      logic [PageW-1:0]  page;
      logic [ProtW-1:0]  prot;
      status_type        status;
      logic [5:0]        elig;
      logic [CountW-1:0] count;
      logic              last;
   } beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hpwl_req_if req_bus ();
   hpwl_rsp_if rsp_bus ();

   hot_page_write_lock_policy_unit #(.TABLE_PAGES(Pages)) dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   command_type pending_cmds[$];
   beat_type    expected_beats[$];
   int          mismatches = 0;
   int          cycle_no = 0;
   bit          stim_done = 0;
   bit          calm;

   bit                tbl_valid[Pages];
   logic [PageW-1:0]  tbl_page[Pages];
   logic              tbl_shared[Pages];
   logic [ProtW-1:0]  tbl_orig[Pages];
   logic [ProtW-1:0]  tbl_cur[Pages];
   logic [CountW-1:0] tbl_count[Pages];

   logic [PageW-1:0] page_pool[48];

   assign calm = (cycle_no > 30000 && cycle_no < 60000);

   function automatic beat_type mk_beat(kind_type k, logic [PageW-1:0] p,
                                        logic [ProtW-1:0] pr, status_type s, logic [5:0] e,
                                        logic [CountW-1:0] c, logic l);
      beat_type b;
      b.kind = k; b.page = p; b.prot = pr; b.status = s; b.elig = e; b.count = c;
      b.last = l;
      return b;
   endfunction

   function automatic int find_entry(logic [PageW-1:0] p);
      for (int i = 0; i < Pages; i++)
         if (tbl_valid[i] && tbl_page[i] == p) return i;
      return -1;
   endfunction

   function automatic bit writable_entry(int i);
      return tbl_valid[i] && !tbl_shared[i] && (tbl_orig[i] & WRITE_BIT) != NO_ACCESS;
   endfunction

   task automatic apply_policy(command_type c);
      int idx;
      int elig;
      int n;
      int best;
      bit ranked[Pages];
      idx = -1; elig = 0; n = 0;
      case (c.mode)
         MODE_TRACK: begin
            idx = find_entry(c.page);
            if (idx < 0)
               for (int j = 0; j < Pages; j++)
                  if (!tbl_valid[j]) begin
                     idx = j;
                     break;
                  end
            if (idx < 0) begin
               expected_beats.push_back(mk_beat(KIND_ACK, '0, '0, STATUS_FULL, '0, '0, 1'b1));
            end else begin
               tbl_valid[idx] = 1; tbl_page[idx] = c.page; tbl_shared[idx] = c.shared;
               tbl_orig[idx] = c.prot; tbl_cur[idx] = c.prot; tbl_count[idx] = '0;
               expected_beats.push_back(mk_beat(KIND_ACK, '0, '0, STATUS_OK, '0, '0, 1'b1));
            end
         end
         MODE_UNTRACK: begin
            idx = find_entry(c.page);
            if (idx < 0) begin
               expected_beats.push_back(mk_beat(KIND_ACK, '0, '0, STATUS_NOT_FOUND, '0, '0,
                                                1'b1));
            end else begin
               tbl_valid[idx] = 0;
               expected_beats.push_back(mk_beat(KIND_ACK, '0, '0, STATUS_OK, '0, '0, 1'b1));
            end
         end
         MODE_REBALANCE: begin
            for (int i = 0; i < Pages; i++) begin
               ranked[i] = 0;
               if (writable_entry(i)) elig++;
            end
            for (int r = 0; r < elig; r++) begin
               best = -1;
               for (int i = 0; i < Pages; i++) begin
                  if (ranked[i] || !writable_entry(i)) continue;
                  if (best < 0 || tbl_count[i] > tbl_count[best] ||
                      (tbl_count[i] == tbl_count[best] && tbl_page[i] > tbl_page[best]))
                     best = i;
               end
               if (best < 0) break;
               ranked[best] = 1;
               if (n >= MaxActions) continue;
               if (r < c.keep) begin
                  if ((tbl_cur[best] & WRITE_BIT) == NO_ACCESS) begin
                     tbl_cur[best] = tbl_orig[best];
                     if (tbl_count[best] != COUNT_MAX) tbl_count[best]++;
                     expected_beats.push_back(mk_beat(KIND_PROTECT, tbl_page[best],
                        tbl_cur[best], STATUS_OK, '0, tbl_count[best], 1'b0));
                     n++;
                  end
               end else if ((tbl_cur[best] & WRITE_BIT) != NO_ACCESS) begin
                  tbl_cur[best] = tbl_orig[best] & ~c.mask;
                  expected_beats.push_back(mk_beat(KIND_PROTECT, tbl_page[best],
                     tbl_cur[best], STATUS_OK, '0, tbl_count[best], 1'b0));
                  n++;
               end
            end
            expected_beats.push_back(mk_beat(KIND_DONE, '0, '0, STATUS_OK, elig[5:0], '0,
                                             1'b1));
         end
         default: begin
            expected_beats.push_back(mk_beat(KIND_ACK, '0, '0, STATUS_OK, '0, '0, 1'b1));
         end
      endcase
   endtask

   // driver
   initial begin
      req_bus.valid = 0; req_bus.mode = MODE_TRACK; req_bus.page_number = '0;
      req_bus.shared_mapping = 0; req_bus.page_prot = '0; req_bus.keep_count = '0;
      req_bus.lock_mask = '0; rsp_bus.ready = 0;
   end

   command_type cur_cmd;
   bit          req_fire;

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      req_fire = !reset && req_bus.valid && req_bus.ready;
      if (req_fire) apply_policy(cur_cmd);
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_bus.valid || req_fire) begin
            if (pending_cmds.size() > 0 &&
                (calm || $urandom_range(99) >= 16) &&
                !(pending_cmds[0].drain_first && expected_beats.size() > 0)) begin
               cur_cmd = pending_cmds.pop_front();
               req_bus.valid <= 1;
               req_bus.mode <= cur_cmd.mode;
               req_bus.page_number <= cur_cmd.page;
               req_bus.shared_mapping <= cur_cmd.shared;
               req_bus.page_prot <= cur_cmd.prot;
               req_bus.keep_count <= cur_cmd.keep;
               req_bus.lock_mask <= cur_cmd.mask;
            end else begin
               req_bus.valid <= 0;
               if (pending_cmds.size() == 0) stim_done = 1;
            end
         end
         rsp_bus.ready <= calm || $urandom_range(99) >= 16;
      end
   end

   // monitor
   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat kind=%0d page=%h", rsp_bus.kind, rsp_bus.out_page);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_bus.kind !== want.kind || rsp_bus.out_page !== want.page ||
                rsp_bus.new_prot !== want.prot || rsp_bus.status !== want.status ||
                rsp_bus.eligible_count !== want.elig || rsp_bus.page_count !== want.count ||
                rsp_bus.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat mismatch exp k=%0d pg=%h pr=%0d st=%0d el=%0d c=%0d l=%0b act k=%0d pg=%h pr=%0d st=%0d el=%0d c=%0d l=%0b",
                     want.kind, want.page, want.prot, want.status, want.elig, want.count,
                     want.last, rsp_bus.kind, rsp_bus.out_page, rsp_bus.new_prot,
                     rsp_bus.status, rsp_bus.eligible_count, rsp_bus.page_count,
                     rsp_bus.last);
            end
         end
      end
   end

   function automatic command_type mk_cmd(mode_type m, logic [PageW-1:0] p, logic s,
                                          logic [ProtW-1:0] pr, logic [KeepW-1:0] k,
                                          logic [ProtW-1:0] msk);
      command_type c;
      c.mode = m; c.page = p; c.shared = s; c.prot = pr; c.keep = k; c.mask = msk;
      c.drain_first = 0;
      return c;
   endfunction

   initial begin
      command_type c;
      int r;
      page_pool[0] = '0;
      page_pool[1] = '1;
      for (int i = 2; i < 48; i++) page_pool[i] = PageW'({$urandom, $urandom});
      for (int i = 0; i < Pages; i++) tbl_valid[i] = 0;

      // directed
      pending_cmds.push_back(mk_cmd(MODE_UNTRACK, '1, 1'b0, 3'd0, 6'd0, 3'd0));
      pending_cmds.push_back(mk_cmd(MODE_NOP, '1, 1'b1, 3'd7, 6'd63, 3'd7));
      pending_cmds.push_back(mk_cmd(MODE_REBALANCE, '0, 1'b0, 3'd0, 6'd0, 3'd7));
      pending_cmds.push_back(mk_cmd(MODE_TRACK, '0, 1'b0, 3'd7, 6'd0, 3'd0));
      pending_cmds.push_back(mk_cmd(MODE_TRACK, '1, 1'b0, 3'd2, 6'd0, 3'd0));
      pending_cmds.push_back(mk_cmd(MODE_TRACK, page_pool[2], SHARED_FLAG, 3'd7, 6'd0, 3'd0));
      pending_cmds.push_back(mk_cmd(MODE_TRACK, page_pool[3], 1'b0, 3'd5, 6'd0, 3'd0));
      pending_cmds.push_back(mk_cmd(MODE_REBALANCE, '0, 1'b0, 3'd0, 6'd0, 3'd5));
      pending_cmds.push_back(mk_cmd(MODE_REBALANCE, '0, 1'b0, 3'd0, 6'd1, 3'd2));
      pending_cmds.push_back(mk_cmd(MODE_REBALANCE, '0, 1'b0, 3'd0, 6'd63, 3'd0));
      pending_cmds.push_back(mk_cmd(MODE_REBALANCE, '0, 1'b0, 3'd0, 6'd0, 3'd7));
      pending_cmds.push_back(mk_cmd(MODE_TRACK, '0, 1'b0, 3'd6, 6'd0, 3'd0));
      pending_cmds.push_back(mk_cmd(MODE_UNTRACK, page_pool[3], 1'b0, 3'd0, 6'd0, 3'd0));
      for (int i = 0; i < Pages + 1; i++)
         pending_cmds.push_back(mk_cmd(MODE_TRACK, page_pool[4 + i],
                                       1'($urandom_range(1)), ProtW'($urandom_range(7)),
                                       6'd0, 3'd0));
      pending_cmds.push_back(mk_cmd(MODE_REBALANCE, '0, 1'b0, 3'd0, 6'd32, 3'd2));
      pending_cmds.push_back(mk_cmd(MODE_REBALANCE, '0, 1'b0, 3'd0, 6'd0, 3'd7));
      pending_cmds.push_back(mk_cmd(MODE_REBALANCE, '0, 1'b0, 3'd0, 6'd32, 3'd2));

      // random
      for (int n = 0; n < 400; n++) begin
         r = $urandom_range(99);
         if (r < 42)
            c = mk_cmd(MODE_TRACK, page_pool[$urandom_range(47)], $urandom_range(99) < 20,
                       ProtW'($urandom_range(7)), KeepW'($urandom), ProtW'($urandom));
         else if (r < 57)
            c = mk_cmd(MODE_UNTRACK, page_pool[$urandom_range(47)], 1'($urandom_range(1)),
                       ProtW'($urandom), KeepW'($urandom), ProtW'($urandom));
         else if (r < 95)
            c = mk_cmd(MODE_REBALANCE, PageW'({$urandom, $urandom}), 1'($urandom_range(1)),
                       ProtW'($urandom),
                       KeepW'(($urandom_range(9) == 0) ? $urandom_range(63)
                                                       : $urandom_range(12)),
                       ProtW'($urandom_range(7)));
         else
            c = mk_cmd(MODE_NOP, PageW'({$urandom, $urandom}), 1'($urandom_range(1)),
                       ProtW'($urandom), KeepW'($urandom), ProtW'($urandom));
         if (n == 100 || n == 300) c.drain_first = 1;
         pending_cmds.push_back(c);
      end

      repeat (11) @(posedge clock);
      reset <= 0;
      wait (stim_done && expected_beats.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_beats.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
